[src/utf8_to_wide_transcoder_defines.svh]
// assertion macros for the utf8 to wide transcoder
`ifndef UTF8_TO_WIDE_TRANSCODER_DEFINES_SVH
`define UTF8_TO_WIDE_TRANSCODER_DEFINES_SVH

// checked at every clock edge outside reset
`define UTF8W_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every clock edge, reset included
`define UTF8W_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/utf8w_pkg.sv]
// types and constants shared by the utf8 to wide transcoder
`default_nettype none
package utf8w_pkg;

  localparam int unsigned CodeW = 21;

  localparam logic [CodeW-1:0] ReplChar    = 21'h00FFFD;
  localparam logic [CodeW-1:0] MaxPoint    = 21'h10FFFF;
  localparam logic [CodeW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CodeW-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CodeW-1:0] LowSurrBase = 21'h00DC00;
  localparam logic [CodeW-1:0] Plane1      = 21'h010000;
  localparam logic [CodeW-1:0] Least2      = 21'h000080;
  localparam logic [CodeW-1:0] Least3      = 21'h000800;

  typedef enum logic [2:0] {
    LenNone = 3'd0,
    Len1    = 3'd1,
    Len2    = 3'd2,
    Len3    = 3'd3,
    Len4    = 3'd4
  } utf8w_len_e;

  // what one request produces: replacements first, then an optional code point
  typedef struct packed {
    logic [2:0]       repl_cnt;
    logic             has_point;
    logic             pair;
    logic [CodeW-1:0] point;
    logic             last;
    logic [2:0]       unit_cnt;
  } utf8w_desc_t;

endpackage
`default_nettype wire

[src/utf8w_byte_if.sv]
// byte channel into the transcoder
`default_nettype none
interface utf8w_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

[src/utf8w_unit_if.sv]
// code unit channel out of the transcoder
`default_nettype none
interface utf8w_unit_if import utf8w_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_unit;
  logic             replaced;
  logic             out_last;

  modport source (output valid, output code_unit, output replaced, output out_last,
                  input ready);
  modport sink (input valid, input code_unit, input replaced, input out_last,
                output ready);
endinterface
`default_nettype wire

[src/utf8w_decode.sv]
// sequence state and per-byte decode into a unit descriptor
`default_nettype none
module utf8w_decode import utf8w_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  input  wire logic        wide_i,
  output utf8w_desc_t      desc_o
);

  logic [CodeW-1:0] partial_q, partial_d;
  utf8w_len_e       exp_q, exp_d;
  logic [1:0]       held_q, held_d;

  utf8w_len_e       lead;
  logic [2:0]       held;
  logic [CodeW-1:0] shifted;
  logic [CodeW-1:0] least;
  logic             bad_val;
  logic             is_cont;
  logic             restart;
  logic [2:0]       repl;
  logic             has_point;
  logic [CodeW-1:0] point;
  logic             pair;

  always_comb begin
    if (!in_byte_i[7]) begin
      lead = Len1;
    end else if (in_byte_i[7:5] == 3'b110) begin
      lead = Len2;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      lead = Len3;
    end else if (in_byte_i[7:3] == 5'b11110) begin
      lead = Len4;
    end else begin
      lead = LenNone;
    end
  end

  always_comb begin
    unique case (exp_q)
      Len2:    least = Least2;
      Len3:    least = Least3;
      default: least = Plane1;
    endcase
  end

  assign is_cont = (in_byte_i[7:6] == 2'b10);
  assign held    = {1'b0, held_q} + 3'd1;
  assign shifted = {partial_q[CodeW-7:0], in_byte_i[5:0]};
  assign bad_val = (shifted < least) || (shifted > MaxPoint) ||
                   ((shifted >= SurrLo) && (shifted <= SurrHi));

  always_comb begin
    partial_d = partial_q;
    exp_d     = exp_q;
    held_d    = held_q;
    restart   = 1'b1;
    repl      = 3'd0;
    has_point = 1'b0;
    point     = '0;

    if (exp_q != LenNone) begin
      if (is_cont) begin
        restart   = 1'b0;
        partial_d = shifted;
        if (held >= 3'(exp_q)) begin
          if (bad_val) begin
            repl = held;
          end else begin
            has_point = 1'b1;
            point     = shifted;
          end
          exp_d  = LenNone;
          held_d = 2'd0;
        end else if (in_last_i) begin
          repl   = held;
          exp_d  = LenNone;
          held_d = 2'd0;
        end else begin
          held_d = held[1:0];
        end
      end else begin
        repl   = {1'b0, held_q};
        exp_d  = LenNone;
        held_d = 2'd0;
      end
    end

    if (restart) begin
      unique case (lead)
        LenNone: repl = repl + 3'd1;
        Len1: begin
          has_point = 1'b1;
          point     = CodeW'(in_byte_i);
        end
        default: begin
          unique case (lead)
            Len2:    partial_d = CodeW'(in_byte_i[4:0]);
            Len3:    partial_d = CodeW'(in_byte_i[3:0]);
            default: partial_d = CodeW'(in_byte_i[2:0]);
          endcase
          exp_d  = lead;
          held_d = 2'd1;
          if (in_last_i) begin
            repl = repl + 3'd1;
          end
        end
      endcase
    end

    // the end of a string always closes the sequence
    if (in_last_i) begin
      exp_d  = LenNone;
      held_d = 2'd0;
    end
    if (exp_d == LenNone) begin
      partial_d = '0;
    end
  end

  assign pair = wide_i && has_point && (point >= Plane1);

  always_comb begin
    desc_o.repl_cnt  = repl;
    desc_o.has_point = has_point;
    desc_o.pair      = pair;
    desc_o.point     = point;
    desc_o.last      = in_last_i;
    desc_o.unit_cnt  = repl + (has_point ? (pair ? 3'd2 : 3'd1) : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      exp_q     <= LenNone;
      held_q    <= 2'd0;
    end else if (advance_i) begin
      partial_q <= partial_d;
      exp_q     <= exp_d;
      held_q    <= held_d;
    end
  end

endmodule
`default_nettype wire

[src/utf8w_serialiser.sv]
// result register that hands out the units of one descriptor in turn
`default_nettype none
module utf8w_serialiser import utf8w_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  wire utf8w_desc_t desc_i,
  output logic       ready_o,
  utf8w_unit_if.source out_o
);

  utf8w_desc_t      desc_q;
  logic             valid_q;
  logic [1:0]       idx_q;

  logic             final_unit;
  logic             done;
  logic [2:0]       pos;
  logic [2:0]       k;
  logic [19:0]      v;
  logic [CodeW-1:0] hi_unit;
  logic [CodeW-1:0] lo_unit;

  assign pos        = {1'b0, idx_q};
  assign k          = pos - desc_q.repl_cnt;
  assign final_unit = (pos + 3'd1) == desc_q.unit_cnt;
  assign done       = valid_q && out_o.ready && final_unit;
  assign ready_o    = !valid_q || done;

  assign v       = 20'(desc_q.point - Plane1);
  assign hi_unit = SurrLo + CodeW'(v[19:10]);
  assign lo_unit = LowSurrBase + CodeW'(v[9:0]);

  always_comb begin
    out_o.valid    = valid_q;
    out_o.out_last = desc_q.last && final_unit;
    if (pos < desc_q.repl_cnt) begin
      out_o.code_unit = ReplChar;
      out_o.replaced  = 1'b1;
    end else if (k == 3'd0) begin
      out_o.code_unit = desc_q.pair ? hi_unit : desc_q.point;
      out_o.replaced  = 1'b0;
    end else begin
      out_o.code_unit = lo_unit;
      out_o.replaced  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (ready_o) begin
      valid_q <= load_i;
      idx_q   <= 2'd0;
    end else if (out_o.ready) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      desc_q <= desc_i;
    end
  end

endmodule
`default_nettype wire

[src/utf8_to_wide_transcoder.sv]
// utf8 to wide transcoder: top level
//
// in_i takes one utf-8 byte per request with a last mark on the final byte of
// a string; out_o gives code units (whole code points, or utf-16 units with
// surrogate pairs when the mode bit is set), each with a replacement flag and
// a last mark on the final unit of the last byte. cfg_we_i writes the mode bit
// from cfg_wdata_i; write it only while the block is idle.
// a byte is held in the input register, is decoded against the open sequence
// into a descriptor and, if it gives units, lands in the result register,
// from which its first unit shows on out_o.
// while out_o is ready, a byte that gives no unit or one unit leaves room for
// the next byte every cycle; a byte that gives n units (up to four) holds the
// result register as the unit index counter steps, one unit per cycle.
// reset closes any open sequence, empties both registers and selects utf-16
// output. when out_o is stalled the result register holds its unit, the input
// register fills and in_i.ready drops until units drain.
`default_nettype none
`include "utf8_to_wide_transcoder_defines.svh"
module utf8_to_wide_transcoder import utf8w_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cfg_we_i,
  input  wire logic    cfg_wdata_i,
  utf8w_byte_if.sink   in_i,
  utf8w_unit_if.source out_o
);

  logic        wide_q;
  logic        in_v_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        ser_ready;
  logic        desc_load;
  utf8w_desc_t desc;

  assign desc_load  = in_v_q && ser_ready;
  assign in_i.ready = !in_v_q || desc_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b1;
    end else if (cfg_we_i) begin
      wide_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.in_last;
    end
  end

  utf8w_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (desc_load),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .wide_i    (wide_q),
    .desc_o    (desc)
  );

  utf8w_serialiser u_serialiser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_v_q && (desc.unit_cnt != 3'd0)),
    .desc_i  (desc),
    .ready_o (ser_ready),
    .out_o   (out_o)
  );

  `UTF8W_ASSERT(a_repl_value, out_o.valid && out_o.replaced |-> out_o.code_unit == ReplChar, "replacement unit is not U+FFFD")
  `UTF8W_ASSERT(a_no_surr_whole, out_o.valid && !wide_q && !out_o.replaced |-> !((out_o.code_unit >= SurrLo) && (out_o.code_unit <= SurrHi)), "surrogate in whole code point mode")
  `UTF8W_ASSERT(a_unit_range, out_o.valid |-> out_o.code_unit <= MaxPoint, "code unit above U+10FFFF")
  `UTF8W_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_o.valid, "result register not empty after reset")

endmodule
`default_nettype wire
